// File: sv/owssn_pkg.sv
package owssn_pkg;

    // ROM size in bytes and width of the two countdown timers
    localparam int ROM_BYTES  = 8;
    localparam int TIMER_BITS = 12;
    localparam int ROM_BITS   = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    localparam logic [7:0] CMD_READ_ROM = 8'h33;

    typedef logic [TIMER_BITS-1:0] timer_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RESET = 3'd1,
        PH_PWAIT = 3'd2,
        PH_PULSE = 3'd3,
        PH_CMD   = 3'd4,
        PH_ROM   = 3'd5
    } phase_t;

    // Register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_ROM_ID          = 3'd0,
        REG_SAMPLE_DELAY    = 3'd1,
        REG_READ_VALID_TIME = 3'd2,
        REG_RESET_LOW_TIME  = 3'd3,
        REG_PRESENCE_WAIT   = 3'd4,
        REG_PRESENCE_LENGTH = 3'd5
    } reg_idx_t;

endpackage

// File: sv/one_wire_serial_number_slave.sv
// Slave side of a 1-Wire serial-number device, stepped once per microsecond
// tick: each request carries the master's drive of the bus for one tick, and
// each result gives the bus level seen (slave drive ANDed with the master's)
// and the protocol phase after that tick. The block detects a reset low
// pulse, answers with a presence pulse, shifts in a command byte LSB first,
// and on Read ROM (0x33) sends the 64-bit serial number LSB first in read
// slots; any other command returns it to idle. One request is taken every
// clock while in_stall is low, its result registered in the output register
// or, while the output is held, in the skid stage. The tick update is a
// single pass of logic on the state registers. A two-deep output (result
// register plus skid stage) keeps requests flowing while a result waits, so
// in_stall rises only when both are full. Timings are set through the APB
// port, 8-byte stride; the user writes them only while idle (not enforced).
module one_wire_serial_number_slave
    import owssn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  line_in,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  line_out,
    output logic [2:0]            phase,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ROM_BITS-1:0] rom_id_reg;
    timer_t              sample_delay_reg;
    timer_t              read_valid_time_reg;
    timer_t              reset_low_time_reg;
    timer_t              presence_wait_reg;
    timer_t              presence_length_reg;

    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_id_reg          <= '0;
            sample_delay_reg    <= timer_t'(15);
            read_valid_time_reg <= timer_t'(15);
            reset_low_time_reg  <= timer_t'(480);
            presence_wait_reg   <= timer_t'(15);
            presence_length_reg <= timer_t'(60);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_ROM_ID:          rom_id_reg          <= pwdata;
                REG_SAMPLE_DELAY:    sample_delay_reg    <= pwdata[TIMER_BITS-1:0];
                REG_READ_VALID_TIME: read_valid_time_reg <= pwdata[TIMER_BITS-1:0];
                REG_RESET_LOW_TIME:  reset_low_time_reg  <= pwdata[TIMER_BITS-1:0];
                REG_PRESENCE_WAIT:   presence_wait_reg   <= pwdata[TIMER_BITS-1:0];
                REG_PRESENCE_LENGTH: presence_length_reg <= pwdata[TIMER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back; addresses beyond the list read as zero
    always_comb
    begin
        case (cfg_idx)
            REG_ROM_ID:          prdata = rom_id_reg;
            REG_SAMPLE_DELAY:    prdata = CFG_DATA_W'(sample_delay_reg);
            REG_READ_VALID_TIME: prdata = CFG_DATA_W'(read_valid_time_reg);
            REG_RESET_LOW_TIME:  prdata = CFG_DATA_W'(reset_low_time_reg);
            REG_PRESENCE_WAIT:   prdata = CFG_DATA_W'(presence_wait_reg);
            REG_PRESENCE_LENGTH: prdata = CFG_DATA_W'(presence_length_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Protocol state
    // ------------------------------------------------------------------
    phase_t     phase_reg,        phase_next;
    logic [3:0] bit_count_reg,    bit_count_next;
    logic [3:0] byte_count_reg,   byte_count_next;
    logic [7:0] shifter_reg,      shifter_next;
    logic       last_level_reg,   last_level_next;
    logic       slave_drive_reg,  slave_drive_next;
    timer_t     slot_cnt_reg,     slot_cnt_next;
    logic       slot_armed_reg,   slot_armed_next;
    timer_t     reset_cnt_reg,    reset_cnt_next;
    logic       reset_armed_reg,  reset_armed_next;

    logic       in_accept;
    logic       slot_hit;
    logic       reset_hit;
    logic [7:0] rom_byte;

    assign in_accept = in_valid & ~in_stall;

    // Next state: timers count down first, expiries act (slot before reset,
    // so a reset wins a tie), then the line sample is checked for edges.
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        byte_count_next  = byte_count_reg;
        shifter_next     = shifter_reg;
        last_level_next  = last_level_reg;
        slave_drive_next = slave_drive_reg;
        slot_cnt_next    = slot_cnt_reg;
        slot_armed_next  = slot_armed_reg;
        reset_cnt_next   = reset_cnt_reg;
        reset_armed_next = reset_armed_reg;
        slot_hit         = 1'b0;
        reset_hit        = 1'b0;
        rom_byte         = '0;

        if (in_accept)
        begin
            // Slot timer
            if (slot_armed_reg)
            begin
                if (slot_cnt_reg <= timer_t'(1))
                begin
                    slot_cnt_next   = '0;
                    slot_armed_next = 1'b0;
                    slot_hit        = 1'b1;
                end
                else
                begin
                    slot_cnt_next = slot_cnt_reg - timer_t'(1);
                end
            end

            // Reset-low detector
            if (reset_armed_reg)
            begin
                if (reset_cnt_reg <= timer_t'(1))
                begin
                    reset_cnt_next   = '0;
                    reset_armed_next = 1'b0;
                    reset_hit        = 1'b1;
                end
                else
                begin
                    reset_cnt_next = reset_cnt_reg - timer_t'(1);
                end
            end

            if (slot_hit)
            begin
                case (phase_reg)
                    PH_PWAIT:
                    begin
                        slave_drive_next = 1'b0;
                        phase_next       = PH_PULSE;
                        slot_cnt_next    = presence_length_reg;
                        slot_armed_next  = 1'b1;
                    end
                    PH_PULSE:
                    begin
                        slave_drive_next = 1'b1;
                        bit_count_next   = '0;
                        shifter_next     = '0;
                        phase_next       = PH_CMD;
                    end
                    PH_CMD:
                    begin
                        // take the bit from the previous tick's level
                        shifter_next   = {last_level_reg, shifter_reg[7:1]};
                        bit_count_next = bit_count_reg + 4'd1;
                        if (bit_count_next == 4'd8)
                        begin
                            if (shifter_next == CMD_READ_ROM)
                            begin
                                bit_count_next  = '0;
                                byte_count_next = '0;
                                phase_next      = PH_ROM;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_ROM:
                    begin
                        slave_drive_next = 1'b1;
                        if (byte_count_reg >= 4'(ROM_BYTES))
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end

            if (reset_hit)
            begin
                phase_next      = PH_RESET;
                slot_armed_next = 1'b0;
            end

            if (!line_in && last_level_reg)
            begin
                // Falling edge
                if (phase_next == PH_CMD)
                begin
                    slot_cnt_next   = sample_delay_reg;
                    slot_armed_next = 1'b1;
                end
                else if (phase_next == PH_ROM)
                begin
                    if (byte_count_next >= 4'(ROM_BYTES))
                    begin
                        // past the last ROM bit: release
                        slave_drive_next = 1'b1;
                    end
                    else
                    begin
                        rom_byte = rom_id_reg[{byte_count_next[2:0], 3'b000} +: 8];
                        if (bit_count_next == 4'd0)
                        begin
                            shifter_next = rom_byte;
                        end
                        slave_drive_next = shifter_next[0];
                        shifter_next     = {1'b0, shifter_next[7:1]};
                        bit_count_next   = bit_count_next + 4'd1;
                        if (bit_count_next >= 4'd8)
                        begin
                            bit_count_next  = '0;
                            byte_count_next = byte_count_next + 4'd1;
                        end
                    end
                    slot_cnt_next   = read_valid_time_reg;
                    slot_armed_next = 1'b1;
                end
                reset_cnt_next   = reset_low_time_reg;
                reset_armed_next = 1'b1;
            end
            else if (line_in && !last_level_reg)
            begin
                // Rising edge
                if (phase_next == PH_RESET)
                begin
                    phase_next      = PH_PWAIT;
                    slot_cnt_next   = presence_wait_reg;
                    slot_armed_next = 1'b1;
                end
                reset_armed_next = 1'b0;
                reset_cnt_next   = '0;
            end

            last_level_next = line_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            byte_count_reg  <= '0;
            shifter_reg     <= '0;
            last_level_reg  <= 1'b1;
            slave_drive_reg <= 1'b1;
            slot_cnt_reg    <= '0;
            slot_armed_reg  <= 1'b0;
            reset_cnt_reg   <= '0;
            reset_armed_reg <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            byte_count_reg  <= byte_count_next;
            shifter_reg     <= shifter_next;
            last_level_reg  <= last_level_next;
            slave_drive_reg <= slave_drive_next;
            slot_cnt_reg    <= slot_cnt_next;
            slot_armed_reg  <= slot_armed_next;
            reset_cnt_reg   <= reset_cnt_next;
            reset_armed_reg <= reset_armed_next;
        end
    end

    // ------------------------------------------------------------------
    // Result fields for the current request
    // ------------------------------------------------------------------
    logic   res_line;
    phase_t res_phase;

    always_comb
    begin
        res_line  = slave_drive_next & line_in;
        res_phase = phase_next;
    end

    // ------------------------------------------------------------------
    // Output register plus skid stage
    // ------------------------------------------------------------------
    logic   out_valid_reg,  out_valid_next;
    logic   out_line_reg,   out_line_next;
    phase_t out_phase_reg,  out_phase_next;
    logic   skid_valid_reg, skid_valid_next;
    logic   skid_line_reg,  skid_line_next;
    phase_t skid_phase_reg, skid_phase_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_line_next   = out_line_reg;
        out_phase_next  = out_phase_reg;
        skid_valid_next = skid_valid_reg;
        skid_line_next  = skid_line_reg;
        skid_phase_next = skid_phase_reg;

        if (!out_valid_reg || !out_stall)
        begin
            // output slot frees up: drain the skid stage first
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_line_next   = skid_line_reg;
                out_phase_next  = skid_phase_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_accept)
            begin
                out_valid_next = 1'b1;
                out_line_next  = res_line;
                out_phase_next = res_phase;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            // output held: park the new result
            skid_valid_next = 1'b1;
            skid_line_next  = res_line;
            skid_phase_next = res_phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_line_reg   <= out_line_next;
        out_phase_reg  <= out_phase_next;
        skid_line_reg  <= skid_line_next;
        skid_phase_reg <= skid_phase_next;
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign line_out  = out_line_reg;
    assign phase     = 3'(out_phase_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The skid stage fills only behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with output register empty");

    // The slot timer only runs in the presence and data phases
    a_slot_phase: assert property (@(posedge clk) disable iff (!rst_n)
        slot_armed_reg |-> (phase_reg != PH_IDLE && phase_reg != PH_RESET))
        else $error("slot timer armed in idle or reset phase");

    // Byte counter never runs past the end of the ROM
    a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= 4'(ROM_BYTES))
        else $error("byte counter past end of ROM");

    // Bit counter never passes a full byte
    a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= 4'd8)
        else $error("bit counter past a full byte");

    // A request taken while the output is free shows up next cycle
    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !skid_valid_reg && (!out_valid_reg || !out_stall))
        |=> (out_valid_reg && !skid_valid_reg))
        else $error("result of accepted request not presented");

endmodule
